// ===== rtl/urmd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants for the ultrasonic range and motor drive unit.
// No dependencies.
package urmd_pkg;

  localparam int ECHO_COUNT_BITS = 16;
  localparam int TIMER_BITS      = 20;
  localparam int RANGE_BITS      = 21;
  localparam int TRIG_BITS       = 10;
  localparam int AMOUNT_BITS     = 10;
  localparam int DIR_BITS        = 2;
  localparam int PHASE_BITS      = 3;
  localparam int ADDR_BITS       = 4;
  localparam int DATA_BITS       = 32;

  localparam logic [ECHO_COUNT_BITS-1:0] COUNT_MAX = {ECHO_COUNT_BITS{1'b1}};
  localparam logic [RANGE_BITS-1:0]      RANGE_MAX = {RANGE_BITS{1'b1}};
  localparam logic [RANGE_BITS-1:0]      MCM_PER_TICK = RANGE_BITS'(17);

  localparam logic [PHASE_BITS-1:0] PH_TRIG  = 3'd0;
  localparam logic [PHASE_BITS-1:0] PH_WAIT  = 3'd1;
  localparam logic [PHASE_BITS-1:0] PH_COUNT = 3'd2;
  localparam logic [PHASE_BITS-1:0] PH_HOLD  = 3'd3;

  localparam logic [DIR_BITS-1:0] DIR_STOP    = 2'd0;
  localparam logic [DIR_BITS-1:0] DIR_FORWARD = 2'd1;
  localparam logic [DIR_BITS-1:0] DIR_REVERSE = 2'd2;

  localparam logic [1:0] REG_TRIGGER_TICKS  = 2'd0;
  localparam logic [1:0] REG_HOLDOFF_TICKS  = 2'd1;
  localparam logic [1:0] REG_STOP_BAND_LOW  = 2'd2;
  localparam logic [1:0] REG_STOP_BAND_HIGH = 2'd3;

  localparam logic [TRIG_BITS-1:0]  TRIGGER_TICKS_RESET  = 10'd10;
  localparam logic [TIMER_BITS-1:0] HOLDOFF_TICKS_RESET  = 20'd60000;
  localparam logic [RANGE_BITS-1:0] STOP_BAND_LOW_RESET  = 21'd18000;
  localparam logic [RANGE_BITS-1:0] STOP_BAND_HIGH_RESET = 21'd22000;

  localparam logic [AMOUNT_BITS-1:0] AMT_0   = 10'd0;
  localparam logic [AMOUNT_BITS-1:0] AMT_50  = 10'd50;
  localparam logic [AMOUNT_BITS-1:0] AMT_100 = 10'd100;
  localparam logic [AMOUNT_BITS-1:0] AMT_150 = 10'd150;
  localparam logic [AMOUNT_BITS-1:0] AMT_200 = 10'd200;
  localparam logic [AMOUNT_BITS-1:0] AMT_300 = 10'd300;
  localparam logic [AMOUNT_BITS-1:0] AMT_400 = 10'd400;
  localparam logic [AMOUNT_BITS-1:0] AMT_500 = 10'd500;
  localparam logic [AMOUNT_BITS-1:0] AMT_600 = 10'd600;

  typedef struct packed {
    logic                  trig;
    logic                  fire;
    logic [RANGE_BITS-1:0] range;
  } step_t;

  typedef struct packed {
    logic [DIR_BITS-1:0]    direction;
    logic [AMOUNT_BITS-1:0] amount;
  } drive_t;

endpackage

// ===== rtl/urmd_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for echo tick words and result words.
// Depends on urmd_pkg.
interface urmd_in_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink (input valid, input echo_level, output ready);
endinterface

interface urmd_out_if import urmd_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic                   trigger_out;
  logic [DIR_BITS-1:0]    drive_direction;
  logic [AMOUNT_BITS-1:0] drive_amount;
  logic                   range_valid;
  logic [RANGE_BITS-1:0]  range_mcm;

  modport source (output valid, output trigger_out, output drive_direction,
                  output drive_amount, output range_valid, output range_mcm,
                  input ready);
  modport sink (input valid, input trigger_out, input drive_direction,
                input drive_amount, input range_valid, input range_mcm,
                output ready);
endinterface

// ===== rtl/urmd_seq.sv =====
`timescale 1ns / 1ps
// Measurement sequencer: trigger, echo wait, echo count with running range, holdoff.
// Depends on urmd_pkg.
module urmd_seq import urmd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  echo,
  input  logic [TRIG_BITS-1:0]  trigger_ticks,
  input  logic [TIMER_BITS-1:0] holdoff_ticks,
  output step_t                 step
);

  logic [PHASE_BITS-1:0]      phase, phase_next;
  logic [TIMER_BITS-1:0]      phase_timer, phase_timer_next;
  logic [ECHO_COUNT_BITS-1:0] echo_count, echo_count_next;
  logic [RANGE_BITS-1:0]      range_acc, range_acc_next;
  logic [TIMER_BITS-1:0]      timer_inc;
  logic [RANGE_BITS:0]        range_sum;

  assign timer_inc = phase_timer + 1'b1;
  assign range_sum = {1'b0, range_acc} + {1'b0, MCM_PER_TICK};

  always_comb begin
    phase_next       = phase;
    phase_timer_next = phase_timer;
    echo_count_next  = echo_count;
    range_acc_next   = range_acc;
    step.trig        = 1'b0;
    step.fire        = 1'b0;
    step.range       = range_acc;
    unique case (phase)
      PH_WAIT: begin
        if (echo) begin
          echo_count_next = ECHO_COUNT_BITS'(1);
          range_acc_next  = MCM_PER_TICK;
          phase_next      = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (echo) begin
          if (echo_count < COUNT_MAX) begin
            echo_count_next = echo_count + 1'b1;
            range_acc_next  = range_sum[RANGE_BITS] ? RANGE_MAX : range_sum[RANGE_BITS-1:0];
          end
        end else begin
          step.fire        = 1'b1;
          phase_timer_next = '0;
          phase_next       = (holdoff_ticks == '0) ? PH_TRIG : PH_HOLD;
        end
      end
      PH_HOLD: begin
        if (timer_inc >= holdoff_ticks) begin
          phase_timer_next = '0;
          phase_next       = PH_TRIG;
        end else begin
          phase_timer_next = timer_inc;
        end
      end
      default: begin
        step.trig = 1'b1;
        if (timer_inc >= TIMER_BITS'(trigger_ticks)) begin
          phase_timer_next = '0;
          phase_next       = PH_WAIT;
        end else begin
          phase_timer_next = timer_inc;
          phase_next       = PH_TRIG;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TRIG;
      phase_timer <= '0;
      echo_count  <= '0;
      range_acc   <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      phase_timer <= phase_timer_next;
      echo_count  <= echo_count_next;
      range_acc   <= range_acc_next;
    end
  end

endmodule

// ===== rtl/urmd_decide.sv =====
`timescale 1ns / 1ps
// Drive decision: dead band test and stepped forward/reverse amount ladders.
// Depends on urmd_pkg.
module urmd_decide import urmd_pkg::*; (
  input  logic [RANGE_BITS-1:0] range,
  input  logic [RANGE_BITS-1:0] band_low,
  input  logic [RANGE_BITS-1:0] band_high,
  output drive_t                drive
);

  logic [AMOUNT_BITS-1:0] fwd_amt, rev_amt;

  always_comb begin
    priority if (range >= 21'd140000) fwd_amt = AMT_600;
    else if (range >= 21'd120000)     fwd_amt = AMT_500;
    else if (range >= 21'd100000)     fwd_amt = AMT_400;
    else if (range >= 21'd80000)      fwd_amt = AMT_300;
    else if (range >= 21'd60000)      fwd_amt = AMT_200;
    else if (range >= 21'd40000)      fwd_amt = AMT_100;
    else                              fwd_amt = AMT_50;
  end

  always_comb begin
    priority if (range >= 21'd15000) rev_amt = AMT_50;
    else if (range >= 21'd12000)     rev_amt = AMT_150;
    else if (range >= 21'd9000)      rev_amt = AMT_300;
    else if (range >= 21'd6000)      rev_amt = AMT_400;
    else if (range >= 21'd3000)      rev_amt = AMT_500;
    else                             rev_amt = AMT_600;
  end

  always_comb begin
    priority if (range > band_low && range < band_high) begin
      drive.direction = DIR_STOP;
      drive.amount    = AMT_0;
    end else if (range <= band_low) begin
      drive.direction = DIR_REVERSE;
      drive.amount    = rev_amt;
    end else begin
      drive.direction = DIR_FORWARD;
      drive.amount    = fwd_amt;
    end
  end

endmodule

// ===== rtl/ultrasonic_range_motor_drive_unit.sv =====
`timescale 1ns / 1ps
// Top level of the ultrasonic range and motor drive unit; uses urmd_seq and urmd_decide.
// A result word is registered and appears in the cycle after its tick word is accepted.
// Throughput: one tick word per cycle; the output register is the only stage, and a new
// word is taken whenever that register is empty or is being drained in the same cycle.
// Reset (rst, synchronous): trigger phase, counters and held command cleared, registers at
// their reset values, no result word pending.
module ultrasonic_range_motor_drive_unit import urmd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  urmd_in_if.sink              ingress,
  urmd_out_if.source           egress,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  logic [TRIG_BITS-1:0]   trigger_ticks;
  logic [TIMER_BITS-1:0]  holdoff_ticks;
  logic [RANGE_BITS-1:0]  stop_band_low;
  logic [RANGE_BITS-1:0]  stop_band_high;
  logic [1:0]             reg_sel;
  logic                   cfg_write;
  logic                   accept;
  logic                   out_valid;
  logic [DIR_BITS-1:0]    held_direction;
  logic [AMOUNT_BITS-1:0] held_amount;
  logic [RANGE_BITS-1:0]  held_range;
  step_t                  step;
  drive_t                 drive;
  drive_t                 drive_next;
  logic [RANGE_BITS-1:0]  range_next;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[ADDR_BITS-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_ticks  <= TRIGGER_TICKS_RESET;
      holdoff_ticks  <= HOLDOFF_TICKS_RESET;
      stop_band_low  <= STOP_BAND_LOW_RESET;
      stop_band_high <= STOP_BAND_HIGH_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_TRIGGER_TICKS:  trigger_ticks  <= pwdata[TRIG_BITS-1:0];
        REG_HOLDOFF_TICKS:  holdoff_ticks  <= pwdata[TIMER_BITS-1:0];
        REG_STOP_BAND_LOW:  stop_band_low  <= pwdata[RANGE_BITS-1:0];
        REG_STOP_BAND_HIGH: stop_band_high <= pwdata[RANGE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TRIGGER_TICKS:  prdata = DATA_BITS'(trigger_ticks);
      REG_HOLDOFF_TICKS:  prdata = DATA_BITS'(holdoff_ticks);
      REG_STOP_BAND_LOW:  prdata = DATA_BITS'(stop_band_low);
      REG_STOP_BAND_HIGH: prdata = DATA_BITS'(stop_band_high);
      default:            prdata = '0;
    endcase
  end

  assign ingress.ready = !out_valid || egress.ready;
  assign accept        = ingress.valid && ingress.ready;

  urmd_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .advance       (accept),
    .echo          (ingress.echo_level),
    .trigger_ticks (trigger_ticks),
    .holdoff_ticks (holdoff_ticks),
    .step          (step)
  );

  urmd_decide u_decide (
    .range     (step.range),
    .band_low  (stop_band_low),
    .band_high (stop_band_high),
    .drive     (drive)
  );

  // Take the new decision on the firing tick, else hold the last one.
  always_comb begin
    if (step.fire) begin
      drive_next = drive;
      range_next = step.range;
    end else begin
      drive_next.direction = held_direction;
      drive_next.amount    = held_amount;
      range_next           = held_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_direction <= DIR_STOP;
      held_amount    <= AMT_0;
      held_range     <= '0;
    end else if (accept) begin
      held_direction <= drive_next.direction;
      held_amount    <= drive_next.amount;
      held_range     <= range_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (egress.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      egress.trigger_out     <= step.trig;
      egress.drive_direction <= drive_next.direction;
      egress.drive_amount    <= drive_next.amount;
      egress.range_valid     <= step.fire;
      egress.range_mcm       <= range_next;
    end
  end

  assign egress.valid = out_valid;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for the ultrasonic range and motor drive unit: a directed plan, then random
// echo measurements, each output word checked against a plan row's word or an in-bench ranging predictor.
// Depends on urmd_pkg, urmd_if and the ultrasonic_range_motor_drive_unit RTL.
module testbench;
  import urmd_pkg::*;

  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned PRESSURE_CYCLES = 300;
  localparam int unsigned SEGMENTS        = 6;
  localparam int unsigned SEG_TICKS       = 100;
  localparam int unsigned MCM_PER_ECHO    = 17;
  localparam int unsigned PLAN_ROWS       = 25;

  typedef enum logic {ROW_TICKS, ROW_WRITE} row_kind_t;

  typedef struct packed {
    logic                   trig;
    logic [DIR_BITS-1:0]    direction;
    logic [AMOUNT_BITS-1:0] amount;
    logic                   fire;
    logic [RANGE_BITS-1:0]  range;
  } tick_word_t;

  typedef struct packed {
    row_kind_t  kind;
    logic       echo;
    logic [31:0] arg;
    logic [1:0] regsel;
    logic       typed;
    tick_word_t want;
  } plan_row_t;

  localparam tick_word_t NO_WANT = '0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_TICKS, 1'b1, 32'd1,       '0, 1'b1, '{1'b1, DIR_STOP, AMT_0, 1'b0, 21'd0}},
    '{ROW_TICKS, 1'b1, 32'd9,       '0, 1'b0, NO_WANT},
    '{ROW_TICKS, 1'b0, 32'd5,       '0, 1'b0, NO_WANT},
    '{ROW_TICKS, 1'b1, 32'd1,       '0, 1'b0, NO_WANT},
    '{ROW_TICKS, 1'b0, 32'd1,       '0, 1'b1, '{1'b0, DIR_REVERSE, AMT_600, 1'b1, 21'd17}},
    '{ROW_WRITE, 1'b0, 32'd1048575, REG_HOLDOFF_TICKS,  1'b0, NO_WANT},
    '{ROW_TICKS, 1'b1, 32'd20,      '0, 1'b1, '{1'b0, DIR_REVERSE, AMT_600, 1'b0, 21'd17}},
    '{ROW_WRITE, 1'b0, 32'd0,       REG_HOLDOFF_TICKS,  1'b0, NO_WANT},
    '{ROW_WRITE, 1'b0, 32'd1,       REG_TRIGGER_TICKS,  1'b0, NO_WANT},
    '{ROW_WRITE, 1'b0, 32'd0,       REG_STOP_BAND_LOW,  1'b0, NO_WANT},
    '{ROW_WRITE, 1'b0, 32'd340,     REG_STOP_BAND_HIGH, 1'b0, NO_WANT},
    '{ROW_TICKS, 1'b0, 32'd3,       '0, 1'b0, NO_WANT},
    '{ROW_TICKS, 1'b1, 32'd10,      '0, 1'b0, NO_WANT},
    '{ROW_TICKS, 1'b0, 32'd1,       '0, 1'b1, '{1'b0, DIR_STOP, AMT_0, 1'b1, 21'd170}},
    '{ROW_WRITE, 1'b0, 32'd0,       REG_TRIGGER_TICKS,  1'b0, NO_WANT},
    '{ROW_TICKS, 1'b1, 32'd2,       '0, 1'b0, NO_WANT},
    '{ROW_TICKS, 1'b1, 32'd19,      '0, 1'b0, NO_WANT},
    '{ROW_TICKS, 1'b0, 32'd1,       '0, 1'b1, '{1'b0, DIR_FORWARD, AMT_50, 1'b1, 21'd340}},
    '{ROW_WRITE, 1'b0, 32'd1114095, REG_STOP_BAND_LOW,  1'b0, NO_WANT},
    '{ROW_WRITE, 1'b0, 32'd0,       REG_STOP_BAND_HIGH, 1'b0, NO_WANT},
    '{ROW_WRITE, 1'b0, 32'd3,       REG_TRIGGER_TICKS,  1'b0, NO_WANT},
    '{ROW_TICKS, 1'b0, 32'd3,       '0, 1'b1, '{1'b1, DIR_FORWARD, AMT_50, 1'b0, 21'd340}},
    '{ROW_TICKS, 1'b0, 32'd4,       '0, 1'b0, NO_WANT},
    '{ROW_TICKS, 1'b1, 32'd200,     '0, 1'b0, NO_WANT},
    '{ROW_TICKS, 1'b0, 32'd1,       '0, 1'b1, '{1'b0, DIR_REVERSE, AMT_500, 1'b1, 21'd3400}}
  };

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  urmd_in_if  echo_ch ();
  urmd_out_if drive_ch ();

  ultrasonic_range_motor_drive_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .ingress (echo_ch),
    .egress  (drive_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [TRIG_BITS-1:0]       cfg_trig;
  logic [TIMER_BITS-1:0]      cfg_hold;
  logic [RANGE_BITS-1:0]      cfg_low;
  logic [RANGE_BITS-1:0]      cfg_high;
  logic [PHASE_BITS-1:0]      ph;
  logic [TIMER_BITS-1:0]      ph_timer;
  logic [ECHO_COUNT_BITS-1:0] echo_cnt;
  logic [DIR_BITS-1:0]        hold_dir;
  logic [AMOUNT_BITS-1:0]     hold_amt;
  logic [RANGE_BITS-1:0]      hold_range;

  tick_word_t  expected_words [$];
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned stall_left;
  int unsigned mismatches;
  int unsigned ticks_sent;
  int unsigned decisions;
  int unsigned n_forward;
  int unsigned n_reverse;
  int unsigned n_stop;
  int unsigned n_saturated;
  int unsigned reg_writes;

  function automatic logic [AMOUNT_BITS-1:0] reverse_amount(logic [RANGE_BITS-1:0] d);
    if (d >= 15000) return AMT_50;
    if (d >= 12000) return AMT_150;
    if (d >= 9000) return AMT_300;
    if (d >= 6000) return AMT_400;
    if (d >= 3000) return AMT_500;
    return AMT_600;
  endfunction

  function automatic logic [AMOUNT_BITS-1:0] forward_amount(logic [RANGE_BITS-1:0] d);
    if (d >= 140000) return AMT_600;
    if (d >= 120000) return AMT_500;
    if (d >= 100000) return AMT_400;
    if (d >= 80000) return AMT_300;
    if (d >= 60000) return AMT_200;
    if (d >= 40000) return AMT_100;
    return AMT_50;
  endfunction

  function automatic tick_word_t advance_ranger(logic echo);
    tick_word_t  w;
    int unsigned d;
    w = '0;
    case (ph)
      PH_WAIT: begin
        if (echo) begin
          echo_cnt = ECHO_COUNT_BITS'(1);
          ph = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (echo) begin
          if (echo_cnt != COUNT_MAX) echo_cnt++;
          else n_saturated++;
        end else begin
          d = echo_cnt * MCM_PER_ECHO;
          if (d > RANGE_MAX) d = 32'(RANGE_MAX);
          hold_range = d[RANGE_BITS-1:0];
          if (hold_range > cfg_low && hold_range < cfg_high) begin
            hold_dir = DIR_STOP;
            hold_amt = AMT_0;
            n_stop++;
          end else if (hold_range <= cfg_low) begin
            hold_dir = DIR_REVERSE;
            hold_amt = reverse_amount(hold_range);
            n_reverse++;
          end else begin
            hold_dir = DIR_FORWARD;
            hold_amt = forward_amount(hold_range);
            n_forward++;
          end
          w.fire = 1'b1;
          ph_timer = '0;
          ph = (cfg_hold == 0) ? PH_TRIG : PH_HOLD;
          decisions++;
        end
      end
      PH_HOLD: begin
        ph_timer++;
        if (ph_timer >= cfg_hold) begin
          ph_timer = '0;
          ph = PH_TRIG;
        end
      end
      default: begin
        w.trig = 1'b1;
        ph_timer++;
        if (ph_timer >= cfg_trig) begin
          ph_timer = '0;
          ph = PH_WAIT;
        end else begin
          ph = PH_TRIG;
        end
      end
    endcase
    w.direction = hold_dir;
    w.amount    = hold_amt;
    w.range     = hold_range;
    return w;
  endfunction

  function automatic int unsigned pick_echo_len();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      n = $urandom_range(180, 360);
    end else if (r < 20) begin
      n = $urandom_range(1, 4);
    end else if (r < 45) begin
      n = ($urandom_range(0, 1) ? cfg_low : cfg_high) / MCM_PER_ECHO + $urandom_range(0, 2);
      if (n > 1) n = n - 1;
      if (n > 60) n = $urandom_range(1, 40);
    end else begin
      n = $urandom_range(1, 40);
    end
    return n;
  endfunction

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  task automatic offer_tick(input logic echo, input logic typed, input tick_word_t typed_want);
    tick_word_t w;
    echo_ch.valid      <= 1'b1;
    echo_ch.echo_level <= echo;
    do @(posedge clk); while (!echo_ch.ready);
    w = advance_ranger(echo);
    expected_words.push_back(typed ? typed_want : w);
    ticks_sent++;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      echo_ch.valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic drain_results();
    echo_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic program_reg(input logic [1:0] regsel, input logic [DATA_BITS-1:0] value);
    logic [DATA_BITS-1:0] stored;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'({regsel, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (regsel)
      REG_TRIGGER_TICKS: begin
        cfg_trig = value[TRIG_BITS-1:0];
        stored = DATA_BITS'(cfg_trig);
      end
      REG_HOLDOFF_TICKS: begin
        cfg_hold = value[TIMER_BITS-1:0];
        stored = DATA_BITS'(cfg_hold);
      end
      REG_STOP_BAND_LOW: begin
        cfg_low = value[RANGE_BITS-1:0];
        stored = DATA_BITS'(cfg_low);
      end
      REG_STOP_BAND_HIGH: begin
        cfg_high = value[RANGE_BITS-1:0];
        stored = DATA_BITS'(cfg_high);
      end
      default: stored = '0;
    endcase
    reg_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== stored)
      flag($sformatf("register %0d read back %0d, expected %0d", regsel, prdata, stored));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : receiver
    drive_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        drive_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        drive_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : word_check
    tick_word_t got;
    tick_word_t want;
    if (!rst && drive_ch.valid && drive_ch.ready) begin
      got = {drive_ch.trigger_out, drive_ch.drive_direction, drive_ch.drive_amount,
             drive_ch.range_valid, drive_ch.range_mcm};
      if (expected_words.size() == 0) begin
        flag("result word with no tick word pending");
      end else begin
        want = expected_words.pop_front();
        if (got.trig !== want.trig || got.direction !== want.direction ||
            got.amount !== want.amount || got.fire !== want.fire ||
            got.range !== want.range)
          flag($sformatf({"word mismatch: expected trig %0d dir %0d amt %0d valid %0d ",
                          "range %0d, got trig %0d dir %0d amt %0d valid %0d range %0d"},
                         want.trig, want.direction, want.amount, want.fire, want.range,
                         got.trig, got.direction, got.amount, got.fire, got.range));
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((echo_ch.valid && echo_ch.ready) || (drive_ch.valid && drive_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned row;
    int unsigned k;
    int unsigned seg;
    int unsigned seg_ticks;
    int unsigned seen_dec;
    int unsigned echo_len;
    int unsigned wait_len;
    int unsigned wait_seen;
    logic [RANGE_BITS-1:0] low_pick;
    logic [31:0] high_pick;
    logic echo;

    rst = 1'b1;
    echo_ch.valid = 1'b0;
    echo_ch.echo_level = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    stall_left = 0;
    mismatches = 0;
    ticks_sent = 0;
    decisions = 0;
    n_forward = 0;
    n_reverse = 0;
    n_stop = 0;
    n_saturated = 0;
    reg_writes = 0;
    tx_idle_pct = 22;
    rx_idle_pct = 61;
    cfg_trig = TRIGGER_TICKS_RESET;
    cfg_hold = HOLDOFF_TICKS_RESET;
    cfg_low = STOP_BAND_LOW_RESET;
    cfg_high = STOP_BAND_HIGH_RESET;
    ph = PH_TRIG;
    ph_timer = '0;
    echo_cnt = '0;
    hold_dir = DIR_STOP;
    hold_amt = AMT_0;
    hold_range = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (row = 0; row < PLAN_ROWS; row++) begin
      if (plan[row].kind == ROW_WRITE) begin
        drain_results();
        program_reg(plan[row].regsel, plan[row].arg);
      end else begin
        for (k = 1; k <= plan[row].arg; k++)
          offer_tick(plan[row].echo, plan[row].typed && k == plan[row].arg, plan[row].want);
      end
    end

    for (seg = 0; seg < SEGMENTS; seg++) begin
      tx_idle_pct = (seg < 2) ? 22 : (seg < 4) ? 61 : 0;
      rx_idle_pct = (seg < 2) ? 61 : (seg < 4) ? 22 : 0;
      drain_results();
      low_pick = ($urandom_range(0, 9) == 0) ? RANGE_BITS'($urandom_range(0, 1114095))
                                             : RANGE_BITS'(MCM_PER_ECHO * $urandom_range(0, 60));
      high_pick = ($urandom_range(0, 4) == 0) ? $urandom_range(0, low_pick)
                                              : low_pick + $urandom_range(0, 680);
      if (high_pick > 1114095) high_pick = 1114095;
      program_reg(REG_TRIGGER_TICKS, ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4));
      program_reg(REG_HOLDOFF_TICKS, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      program_reg(REG_STOP_BAND_LOW, DATA_BITS'(low_pick));
      program_reg(REG_STOP_BAND_HIGH, high_pick);
      if (seg == 0 || seg == 2) stall_left = PRESSURE_CYCLES;
      seg_ticks = 0;
      seen_dec = decisions + 1;
      while (seg_ticks < SEG_TICKS) begin
        if (decisions != seen_dec) begin
          seen_dec = decisions;
          echo_len = pick_echo_len();
          wait_len = $urandom_range(0, 4);
          wait_seen = 0;
        end
        case (ph)
          PH_WAIT: begin
            echo = (wait_seen >= wait_len);
            wait_seen++;
          end
          PH_COUNT: echo = (echo_cnt < echo_len);
          default:  echo = 1'($urandom_range(0, 1));
        endcase
        offer_tick(echo, 1'b0, NO_WANT);
        seg_ticks++;
      end
    end

    drain_results();
    repeat (4) @(posedge clk);

    $display("covered %0d echo ticks and %0d range decisions (%0d forward, %0d reverse, %0d stop)",
             ticks_sent, decisions, n_forward, n_reverse, n_stop);
    $display("with %0d register writes, %0d ticks at echo count saturation, %0d mismatches",
             reg_writes, n_saturated, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
